// ===== sv/crc32c_pkg.sv =====
// ----------------------------------------------------------------------------
// crc32c_pkg
// Shared types, constants and the byte-wide CRC-32C update for the checksum
// block.
// ----------------------------------------------------------------------------
package crc32c_pkg;

  localparam int unsigned POS_W = 13;

  // reflected castagnoli polynomial
  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [POS_W-1:0] MAX_BLOCK_BYTES = 13'd4096;
  localparam logic [POS_W-1:0] POS_MAX = 13'd8191;
  localparam logic [POS_W-1:0] FIELD_BYTES = 13'd4;

  typedef enum logic [1:0] {
    REG_SEED_VALUE   = 2'd0,
    REG_BLOCK_MODE   = 2'd1,
    REG_FIELD_OFFSET = 2'd2,
    REG_BLOCK_SIZE   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [31:0]      seed_value;
    logic             block_mode;
    logic [11:0]      field_offset;
    logic [POS_W-1:0] block_size;
  } cfg_t;

  // one classified byte on its way to the crc engine
  typedef struct packed {
    logic [7:0]  data;
    logic        counts;
    logic        first;
    logic        last;
    logic [31:0] start;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/crc32c_front.sv =====
// ----------------------------------------------------------------------------
// crc32c_front
// Accepts message bytes, tracks the byte position and classifies each byte:
// start value, zeroed checksum field, bytes past the block size.
// ----------------------------------------------------------------------------
module crc32c_front
  import crc32c_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output entry_t     entry
);

  logic             in_message;
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] eff_size;
  logic [POS_W-1:0] field_lo;
  logic [POS_W-1:0] field_hi;
  logic             field_fits;
  logic             in_field;
  logic             in_block;

  always_comb begin
    eff_size   = (cfg.block_size > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : cfg.block_size;
    field_lo   = {1'b0, cfg.field_offset};
    field_hi   = field_lo + FIELD_BYTES;
    field_fits = (field_hi <= eff_size);
    in_field   = field_fits && (byte_position >= field_lo) && (byte_position < field_hi);
    in_block   = (byte_position < eff_size);

    entry.first  = !in_message;
    entry.last   = last_byte;
    entry.start  = cfg.block_mode ? 32'hFFFFFFFF : ~cfg.seed_value;
    entry.counts = !cfg.block_mode || in_block;
    entry.data   = (cfg.block_mode && in_field) ? 8'd0 : data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message    <= 1'b0;
      byte_position <= '0;
    end else if (accept) begin
      if (last_byte) begin
        in_message    <= 1'b0;
        byte_position <= '0;
      end else begin
        in_message <= 1'b1;
        if (byte_position < POS_MAX) begin
          byte_position <= byte_position + 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/crc32c_queue.sv =====
// ----------------------------------------------------------------------------
// crc32c_queue
// Two-entry queue between the classifying front and the crc engine.
// ----------------------------------------------------------------------------
module crc32c_queue
  import crc32c_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  entry_t    wr_entry,
  input  logic      rd,
  output entry_t    rd_entry,
  output q_status_t status
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign rd_entry     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/crc32c_back.sv =====
// ----------------------------------------------------------------------------
// crc32c_back
// Crc engine: one byte update per cycle unless a last byte waits for a pop,
// final inversion into the result register at the end of a message.
// ----------------------------------------------------------------------------
module crc32c_back
  import crc32c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  entry_t      q_entry,
  output logic        q_rd,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] crc_value,
  output logic        emit
);

  logic [31:0] running_crc;
  logic [31:0] crc_cur;
  logic [31:0] crc_next;
  logic        out_valid;

  assign empty = !out_valid;

  // a last byte needs room in the result register, which a pop frees at once
  assign q_rd = !q_empty && (!q_entry.last || !out_valid || pop);
  assign emit = q_rd && q_entry.last;

  always_comb begin
    crc_cur  = q_entry.first ? q_entry.start : running_crc;
    crc_next = q_entry.counts ? crc_byte(crc_cur, q_entry.data) : crc_cur;
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      running_crc <= crc_next;
    end
    if (emit) begin
      crc_value <= ~crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== sv/crc32c_block_checksum.sv =====
// ----------------------------------------------------------------------------
// crc32c_block_checksum
// CRC-32C over a byte stream, one result per message, with plain seeded mode
// and block mode (checksum field zeroed, bytes past the block size ignored).
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     push / full      data_byte, last_byte
//  result    empty / pop      crc_value
//  config    wr_en            wr_index, wr_data
//
//  one byte per cycle sustained; the byte-wide crc update in the back end
//  sets that figure. a result reaches the ports through the queue and the
//  result register. reset empties the queue and the result register and
//  clears the position counter. a stalled result holds the back end only at
//  the next last byte; the two-entry queue then fills and raises full.
// ----------------------------------------------------------------------------
module crc32c_block_checksum
  import crc32c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] crc_value,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data
);

  cfg_t      cfg;
  entry_t    f_entry;
  entry_t    q_entry;
  q_status_t q_status;
  logic      accept;
  logic      q_rd;
  logic      emit;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed_value   <= 32'd0;
      cfg.block_mode   <= 1'b0;
      cfg.field_offset <= 12'd0;
      cfg.block_size   <= MAX_BLOCK_BYTES;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_SEED_VALUE:   cfg.seed_value   <= wr_data;
        REG_BLOCK_MODE:   cfg.block_mode   <= wr_data[0];
        REG_FIELD_OFFSET: cfg.field_offset <= wr_data[11:0];
        REG_BLOCK_SIZE:   cfg.block_size   <= wr_data[POS_W-1:0];
        default:          cfg <= cfg;
      endcase
    end
  end

  crc32c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .entry     (f_entry)
  );

  crc32c_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (accept),
    .wr_entry (f_entry),
    .rd       (q_rd),
    .rd_entry (q_entry),
    .status   (q_status)
  );

  crc32c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_status.empty),
    .q_entry   (q_entry),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .crc_value (crc_value),
    .emit      (emit)
  );

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> !empty)
    else $error("finished transaction not shown on result port");

  a_pop_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !emit) |=> empty)
    else $error("result still shown after pop");

  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    q_status.empty |-> !q_rd)
    else $error("crc engine read an empty queue");

endmodule

// ===== tb/crc32c_block_checksum_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32c_block_checksum_tb
// Drives byte messages through the checksum block and checks every crc_value
// it pops against an in-bench CRC-32C predictor that covers plain seeded mode
// and block mode, including field zeroing, truncation and block size limits.
// A short directed table comes first, then randomized phases, each with a
// fresh register setting. Both sides idle at random unless no_gaps is set.
// ----------------------------------------------------------------------------
module crc32c_block_checksum_tb;
  import crc32c_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 1200;
  localparam int unsigned SETTLE_CYCLES  = 8;

  typedef struct {
    bit          cfg_row;
    reg_index_t  idx;
    logic [31:0] value;
    logic [7:0]  data;
    bit          last;
    bit          known;
    logic [31:0] crc;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        empty;
  logic        pop;
  logic [31:0] crc_value;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [31:0] wr_data;

  // predictor state
  cfg_t        cfg;
  logic [31:0] crc_run;
  logic [12:0] msg_pos;
  bit          msg_open;

  logic [31:0] crc_expected [$];
  int unsigned errors;
  int unsigned stuck_cycles;
  bit          no_gaps;
  dir_row_t    dir_rows [$];

  crc32c_block_checksum dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .empty     (empty),
    .pop       (pop),
    .crc_value (crc_value),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic dir_row_t set_row(reg_index_t idx, logic [31:0] value);
    dir_row_t r;
    r = '{cfg_row: 1'b1, idx: idx, value: value, data: 8'h00, last: 1'b0,
          known: 1'b0, crc: 32'h0};
    return r;
  endfunction

  function automatic dir_row_t byte_row(logic [7:0] data, bit last, bit known = 1'b0,
                                        logic [31:0] crc = 32'h0);
    dir_row_t r;
    r = '{cfg_row: 1'b0, idx: REG_SEED_VALUE, value: 32'h0, data: data, last: last,
          known: known, crc: crc};
    return r;
  endfunction

  // bitwise reflected castagnoli update, one byte
  function automatic logic [31:0] crc32c_update(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic bit predict_crc(logic [7:0] data, bit last, output logic [31:0] crc);
    int unsigned eff;
    int unsigned off;
    logic [7:0]  b;
    b = data;
    crc = 32'h0;
    if (!msg_open) begin
      crc_run  = cfg.block_mode ? 32'hFFFF_FFFF : ~cfg.seed_value;
      msg_pos  = '0;
      msg_open = 1'b1;
    end
    if (cfg.block_mode) begin
      eff = (cfg.block_size > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : cfg.block_size;
      off = cfg.field_offset;
      if (msg_pos < eff) begin
        // checksum field reads as zero only when it lies wholly inside the block
        if (off + 4 <= eff && msg_pos >= off && msg_pos < off + 4) b = 8'h00;
        crc_run = crc32c_update(crc_run, b);
      end
    end else begin
      crc_run = crc32c_update(crc_run, b);
    end
    if (msg_pos < POS_MAX) msg_pos = msg_pos + 1'b1;
    if (last) begin
      crc      = ~crc_run;
      msg_open = 1'b0;
      msg_pos  = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = value;
    case (idx)
      REG_SEED_VALUE:   cfg.seed_value   = value;
      REG_BLOCK_MODE:   cfg.block_mode   = value[0];
      REG_FIELD_OFFSET: cfg.field_offset = value[11:0];
      REG_BLOCK_SIZE:   cfg.block_size   = value[12:0];
      default: ;
    endcase
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic push_byte(logic [7:0] data, bit last, bit known = 1'b0,
                           logic [31:0] known_crc = 32'h0);
    int unsigned gap;
    logic [31:0] crc;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push      = 1'b1;
    data_byte = data;
    last_byte = last;
    @(posedge clk);
    while (full) @(posedge clk);
    if (predict_crc(data, last, crc)) crc_expected.push_back(known ? known_crc : crc);
    @(negedge clk);
  endtask

  task automatic send_message(int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      push_byte(8'($urandom_range(0, 255)), k == len - 1);
  endtask

  // hold the sender until every pending result has drained
  task automatic settle();
    push = 1'b0;
    while (crc_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result side: random stalls, check each popped transaction
  initial begin
    int unsigned stall;
    logic [31:0] want;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        pop = 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop = 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (crc_expected.size() == 0) begin
        errors++;
        $display("%0t: crc_value %08h popped with no message pending", $time, crc_value);
      end else begin
        want = crc_expected.pop_front();
        if (crc_value !== want) begin
          errors++;
          $display("%0t: crc_value mismatch, expected %08h, got %08h",
                   $time, want, crc_value);
        end
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, stuck_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned random_items;
    int unsigned n_msgs;
    int unsigned len;
    int unsigned off_hi;
    logic [31:0] seed;
    logic        mode;
    logic [12:0] size;
    logic [11:0] offset;

    rst          = 1'b1;
    push         = 1'b0;
    data_byte    = 8'h00;
    last_byte    = 1'b0;
    wr_en        = 1'b0;
    wr_index     = REG_SEED_VALUE;
    wr_data      = 32'h0;
    errors       = 0;
    stuck_cycles = 0;
    no_gaps      = 1'b0;
    cfg          = '{seed_value: 32'h0, block_mode: 1'b0, field_offset: 12'h0,
                     block_size: MAX_BLOCK_BYTES};
    crc_run      = 32'h0;
    msg_pos      = '0;
    msg_open     = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    dir_rows = '{
      // standard check string at reset settings
      byte_row(8'h31, 0), byte_row(8'h32, 0), byte_row(8'h33, 0),
      byte_row(8'h34, 0), byte_row(8'h35, 0), byte_row(8'h36, 0),
      byte_row(8'h37, 0), byte_row(8'h38, 0), byte_row(8'h39, 1, 1, 32'hE306_9283),
      // all-ones seed starts the register at zero
      set_row(REG_SEED_VALUE, 32'hFFFF_FFFF),
      byte_row(8'h00, 1, 1, 32'hFFFF_FFFF),
      byte_row(8'hFF, 1),
      // block mode with zero block size counts nothing
      set_row(REG_BLOCK_MODE, 32'h1),
      set_row(REG_BLOCK_SIZE, 32'h0),
      byte_row(8'hFF, 0), byte_row(8'h00, 1, 1, 32'h0),
      // field at offset 0 fills the whole block, fifth byte is past the end
      set_row(REG_BLOCK_SIZE, 32'd4),
      set_row(REG_FIELD_OFFSET, 32'd0),
      byte_row(8'hFF, 0), byte_row(8'hFF, 0), byte_row(8'hFF, 0),
      byte_row(8'hFF, 0), byte_row(8'h5A, 1),
      // size above the limit, field past the limit
      set_row(REG_BLOCK_SIZE, 32'd8191),
      set_row(REG_FIELD_OFFSET, 32'd4095),
      byte_row(8'h01, 0), byte_row(8'h7F, 0), byte_row(8'h80, 1),
      // field does not fit in the block, tail bytes truncated
      set_row(REG_BLOCK_SIZE, 32'd3),
      set_row(REG_FIELD_OFFSET, 32'd1),
      byte_row(8'hAA, 0), byte_row(8'h55, 0), byte_row(8'hFF, 0), byte_row(8'h00, 1)
    };

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_row) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        push_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].known, dir_rows[i].crc);
      end
    end

    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS || phase < 6) begin
      settle();
      case ($urandom_range(0, 3))
        0:       seed = 32'h0;
        1:       seed = 32'hFFFF_FFFF;
        default: seed = $urandom;
      endcase
      mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0:       size = 13'd0;
        1:       size = 13'd1;
        2:       size = MAX_BLOCK_BYTES;
        3:       size = 13'($urandom_range(4097, 8191));
        4:       size = 13'd4;
        default: size = 13'($urandom_range(1, 64));
      endcase
      off_hi = (size > 70) ? 70 : size;
      case ($urandom_range(0, 5))
        0:       offset = 12'd0;
        1:       offset = 12'd4095;
        default: offset = 12'($urandom_range(0, off_hi));
      endcase
      // field at the very end of the block, with bytes past the end
      if (phase == 2) begin
        mode   = 1'b1;
        size   = 13'd40;
        offset = 12'd36;
      end else if (phase == 5) begin
        mode   = 1'b1;
        size   = 13'd16;
        offset = 12'd12;
      end
      write_reg(REG_SEED_VALUE, seed);
      write_reg(REG_BLOCK_MODE, {31'h0, mode});
      write_reg(REG_FIELD_OFFSET, {20'h0, offset});
      write_reg(REG_BLOCK_SIZE, {19'h0, size});
      no_gaps = ($urandom_range(0, 3) == 0);

      if (phase == 2 || phase == 5) begin
        send_message(48);
        random_items += 48;
      end else begin
        n_msgs = $urandom_range(2, 8);
        repeat (n_msgs) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 150) : $urandom_range(1, 24);
          send_message(len);
          random_items += len;
        end
      end
      phase++;
    end

    push    = 1'b0;
    no_gaps = 1'b0;
    while (crc_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && crc_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
